// ===== rtl/lwkr_pkg.sv =====
// Shared constants, payload types and count table control for the window search block.
package lwkr_pkg;

    localparam int MAX_LEN_DEF  = 4096;
    localparam int ALPHABET_DEF = 256;
    localparam int CHAR_W       = 8;
    localparam int CHG_W        = 13;
    localparam int OUT_W        = 13;

    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } lwkr_in_t;

    typedef struct packed {
        logic [OUT_W-1:0] longest;
        logic             too_long;
    } lwkr_out_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
    } lwkr_cnt_ctl_t;

endpackage

// ===== rtl/lwkr_count_mem.sv =====
// Character count table: two registered read ports, one write port, per-entry valid bits.
module lwkr_count_mem #(
    parameter int ALPHABET = lwkr_pkg::ALPHABET_DEF,
    parameter int CNT_W    = 13
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  lwkr_pkg::lwkr_cnt_ctl_t     ctl,
    input  logic [$clog2(ALPHABET)-1:0] rd_addr_a,
    input  logic [$clog2(ALPHABET)-1:0] rd_addr_b,
    input  logic [$clog2(ALPHABET)-1:0] wr_addr,
    input  logic [CNT_W-1:0]            wr_data,
    output logic [CNT_W-1:0]            rd_data_a,
    output logic [CNT_W-1:0]            rd_data_b
);

    logic [CNT_W-1:0]    mem [ALPHABET];
    logic [ALPHABET-1:0] valid_reg;
    logic [CNT_W-1:0]    rd_a_reg;
    logic [CNT_W-1:0]    rd_b_reg;
    logic                vld_a_reg;
    logic                vld_b_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en) begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
        end else begin
            if (ctl.rd_en) begin
                vld_a_reg <= valid_reg[rd_addr_a];
                vld_b_reg <= valid_reg[rd_addr_b];
            end
            if (ctl.clear) begin
                valid_reg <= '0;
            end else if (ctl.wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_data_a = vld_a_reg ? rd_a_reg : '0;
    assign rd_data_b = vld_b_reg ? rd_b_reg : '0;

endmodule

// ===== rtl/longest_window_with_k_replacements.sv =====
// Top level: longest window of a byte string that needs at most max_changes replacements.
// Result: a string's result is registered when the work phase after its last byte commits (output free).
// Input: a new byte is taken only in the idle phase, after the work phase of the last one, paced by the
// count table's single write port (one increment and at most one decrement per byte).
// Reset: clears control state and all counts at once through per-entry valid bits;
// the history store is not cleared and no clearing pass runs.
module longest_window_with_k_replacements #(
    parameter int MAX_LEN  = lwkr_pkg::MAX_LEN_DEF,
    parameter int ALPHABET = lwkr_pkg::ALPHABET_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [lwkr_pkg::CHG_W-1:0] cfg_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  lwkr_pkg::lwkr_in_t        s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output lwkr_pkg::lwkr_out_t       m_data
);

    localparam int IW   = $clog2(ALPHABET);
    localparam int AW   = $clog2(MAX_LEN);
    localparam int PW   = $clog2(MAX_LEN + 1);
    localparam int DW   = (PW > lwkr_pkg::CHG_W) ? PW : lwkr_pkg::CHG_W;
    localparam int OW   = (PW > lwkr_pkg::OUT_W) ? PW : lwkr_pkg::OUT_W;
    localparam int RW   = lwkr_pkg::CHAR_W + 9;

    localparam logic PH_IDLE = 1'b0;
    localparam logic PH_WORK = 1'b1;

    function automatic logic [IW-1:0] char_index(input logic [lwkr_pkg::CHAR_W-1:0] c);
        logic [RW-1:0] r;
        logic [RW-1:0] d;
        r = RW'(c);
        for (int k = lwkr_pkg::CHAR_W - 1; k >= 0; k--) begin
            d = RW'(ALPHABET) << k;
            if (r >= d) begin
                r = r - d;
            end
        end
        return r[IW-1:0];
    endfunction

    logic [lwkr_pkg::CHG_W-1:0] max_changes_reg;
    logic                       phase_reg;
    logic                       phase_next;
    logic [PW-1:0]              left_pos_reg;
    logic [PW-1:0]              left_pos_next;
    logic [PW-1:0]              right_pos_reg;
    logic [PW-1:0]              top_count_reg;
    logic [PW-1:0]              best_len_reg;
    logic                       overflowed_reg;

    logic [IW-1:0]              ch_idx_reg;
    logic [IW-1:0]              lidx_reg;
    logic                       last_reg;
    logic                       skip_reg;
    logic                       fwd_a_reg;
    logic                       fwd_b_reg;
    logic [PW-1:0]              fwd_val_reg;

    logic                       dec_pend_reg;
    logic                       dec_pend_next;
    logic [IW-1:0]              dec_addr_reg;
    logic [PW-1:0]              dec_val_reg;

    logic                       m_valid_reg;
    lwkr_pkg::lwkr_out_t        m_data_reg;

    logic [IW-1:0]              hist_mem [MAX_LEN];
    logic [IW-1:0]              hist_q;

    logic                       s_xfer;
    logic [IW-1:0]              ch_idx;
    logic                       in_skip;
    logic                       out_free;
    logic                       commit;
    logic                       step;
    logic [PW-1:0]              rd_a;
    logic [PW-1:0]              rd_b;
    logic [PW-1:0]              cnt_a;
    logic [PW-1:0]              cnt_b;
    logic [PW-1:0]              new_a;
    logic [PW-1:0]              top_n;
    logic [PW-1:0]              win;
    logic [PW-1:0]              win_f;
    logic [PW-1:0]              cur_l;
    logic [PW-1:0]              best_n;
    logic [PW-1:0]              res_best;
    logic [OW-1:0]              res_ext;
    logic                       shrink;
    lwkr_pkg::lwkr_cnt_ctl_t    cnt_ctl;
    logic [IW-1:0]              cnt_wr_addr;
    logic [PW-1:0]              cnt_wr_data;

    assign cfg_ready = 1'b1;
    assign s_ready   = (phase_reg == PH_IDLE);
    assign s_xfer    = s_valid && s_ready;
    assign ch_idx    = char_index(s_data.ch);
    assign in_skip   = (right_pos_reg >= PW'(MAX_LEN));
    assign out_free  = !m_valid_reg || m_ready;
    assign commit    = (phase_reg == PH_WORK) && (!last_reg || out_free);
    assign step      = commit && !last_reg && !skip_reg;

    always_comb begin
        cnt_a  = fwd_a_reg ? fwd_val_reg : rd_a;
        cnt_b  = fwd_b_reg ? fwd_val_reg : rd_b;
        new_a  = cnt_a + PW'(1);
        top_n  = (new_a > top_count_reg) ? new_a : top_count_reg;
        win    = right_pos_reg - left_pos_reg + PW'(1);
        shrink = (win > top_n) && (DW'(win - top_n) > DW'(max_changes_reg));
        win_f  = shrink ? win - PW'(1) : win;
        cur_l  = (lidx_reg == ch_idx_reg) ? new_a : cnt_b;
        best_n = (win_f > best_len_reg) ? win_f : best_len_reg;
        res_best = skip_reg ? best_len_reg : best_n;
        res_ext  = OW'(res_best);
    end

    always_comb begin
        phase_next = phase_reg;
        if (s_xfer) begin
            phase_next = PH_WORK;
        end else if (commit) begin
            phase_next = PH_IDLE;
        end
        left_pos_next = left_pos_reg;
        if (commit && last_reg) begin
            left_pos_next = '0;
        end else if (step && shrink) begin
            left_pos_next = left_pos_reg + PW'(1);
        end
        dec_pend_next = step && shrink && (cur_l != '0);
    end

    always_comb begin
        cnt_ctl.rd_en = s_xfer;
        cnt_ctl.wr_en = step || dec_pend_reg;
        cnt_ctl.clear = commit && last_reg;
        cnt_wr_addr   = dec_pend_reg ? dec_addr_reg : ch_idx_reg;
        cnt_wr_data   = dec_pend_reg ? dec_val_reg : new_a;
    end

    lwkr_count_mem #(
        .ALPHABET (ALPHABET),
        .CNT_W    (PW)
    ) u_counts (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (cnt_ctl),
        .rd_addr_a (ch_idx),
        .rd_addr_b (hist_q),
        .wr_addr   (cnt_wr_addr),
        .wr_data   (cnt_wr_data),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    always_ff @(posedge aclk) begin
        if (s_xfer && !in_skip) begin
            hist_mem[right_pos_reg[AW-1:0]] <= ch_idx;
        end
        hist_q <= hist_mem[left_pos_next[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            ch_idx_reg  <= ch_idx;
            lidx_reg    <= hist_q;
            last_reg    <= s_data.last;
            skip_reg    <= in_skip;
            fwd_a_reg   <= dec_pend_reg && (dec_addr_reg == ch_idx);
            fwd_b_reg   <= dec_pend_reg && (dec_addr_reg == hist_q);
            fwd_val_reg <= dec_val_reg;
        end
        if (step) begin
            dec_addr_reg <= lidx_reg;
            dec_val_reg  <= cur_l - PW'(1);
        end
        if (commit && last_reg) begin
            m_data_reg.longest  <= (res_ext > OW'(lwkr_pkg::OUT_MAX)) ?
                                   lwkr_pkg::OUT_MAX : res_ext[lwkr_pkg::OUT_W-1:0];
            m_data_reg.too_long <= overflowed_reg || skip_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_changes_reg <= '0;
            phase_reg       <= PH_IDLE;
            left_pos_reg    <= '0;
            right_pos_reg   <= '0;
            top_count_reg   <= '0;
            best_len_reg    <= '0;
            overflowed_reg  <= 1'b0;
            dec_pend_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                max_changes_reg <= cfg_data;
            end
            phase_reg    <= phase_next;
            left_pos_reg <= left_pos_next;
            dec_pend_reg <= dec_pend_next;
            if (commit && last_reg) begin
                right_pos_reg  <= '0;
                top_count_reg  <= '0;
                best_len_reg   <= '0;
                overflowed_reg <= 1'b0;
            end else if (step) begin
                right_pos_reg <= right_pos_reg + PW'(1);
                top_count_reg <= top_n;
                best_len_reg  <= best_n;
            end else if (commit) begin
                overflowed_reg <= 1'b1;
            end
            if (commit && last_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_dec_not_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_WORK) |-> !dec_pend_reg)
        else $error("count decrement pending while an increment is due");

    a_left_le_right: assert property (@(posedge aclk) disable iff (!aresetn)
        left_pos_reg <= right_pos_reg)
        else $error("window left end passed right end");

    a_right_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        right_pos_reg <= PW'(MAX_LEN))
        else $error("right position beyond history depth");

    a_xfer_to_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> (phase_reg == PH_WORK))
        else $error("input transfer did not start work phase");

    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && last_reg) |=> m_valid_reg)
        else $error("finished string produced no result");

endmodule
